// ----- rtl/handset_timing_sync_tracker_core_macros.svh -----
// assertion macros for the tracker checker
`ifndef HANDSET_TIMING_SYNC_TRACKER_CORE_MACROS_SVH
`define HANDSET_TIMING_SYNC_TRACKER_CORE_MACROS_SVH

// antecedent implies consequent in the next cycle
`define HTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker check failed");

// antecedent implies consequent in the same cycle
`define HTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker check failed");

`endif

// ----- rtl/hts_pkg.sv -----
package hts_pkg;

   localparam logic [1:0] CMD_GOOD = 2'd0;
   localparam logic [1:0] CMD_BAD  = 2'd1;
   localparam logic [1:0] CMD_RF   = 2'd2;
   localparam logic [1:0] CMD_POLL = 2'd3;

   localparam logic [1:0] KIND_SYNC  = 2'd0;
   localparam logic [1:0] KIND_STATS = 2'd1;
   localparam logic [1:0] KIND_CONN  = 2'd2;
   localparam logic [1:0] KIND_DISC  = 2'd3;

   localparam logic [1:0] REG_INTERVAL = 2'd0;
   localparam logic [1:0] REG_LATCH    = 2'd1;
   localparam logic [1:0] REG_TIMEOUT  = 2'd2;

   localparam logic [16:0] INTERVAL_RESET = 17'd4000;
   localparam logic [16:0] INTERVAL_MAX   = 17'd100000;
   localparam logic [15:0] LATCH_RESET    = 16'd1000;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
   localparam logic [15:0] LIMIT_RESET    = 16'd5;
   localparam logic [31:0] SYNC_PERIOD_MS = 32'd200;
   localparam logic [32:0] SAFE_MARGIN    = 33'd1000;
   localparam logic [47:0] WINDOW_SPAN    = 48'd20000;

   localparam int DIVD_W = 48;
   localparam int DSR_W  = 17;
   localparam int CNT_W  = 6;

   typedef struct packed {
      logic capture;
      logic exec;
      logic lim_start;
      logic mul;
      logic sum;
      logic fin_mod;
      logic fin_avg;
      logic fin_lim;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       rf_ge;
      logic       pend_any;
      logic       slot_free;
      logic       div_done;
   } dp_status_type;

endpackage

// ----- rtl/handset_timing_sync_tracker_core.sv -----
// Handset timing tracker. One request is accepted at a time: a bad frame event is only counted,
// a good frame event raises the connected result when the link was down, a poll raises at most
// three results, each held in the output register until taken, so a stalled result side stalls
// the poll, and an RF-sent event waits on the shared 48-step one-bit-per-cycle divider that
// forms the modulo or the windowed average. A write of packet_interval_us drops req_tready
// while the same divider recomputes the averaging window. A sync result carries the interval
// times ten and the averaged offset less 1000 in tenths of a microsecond; tally width is set
// by TALLY_BITS.
module handset_timing_sync_tracker_core
   import hts_pkg::*;
#(
   parameter int TALLY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [63:0] req_tdata,   // time_us, time_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   output logic [87:0] rsp_tdata,   // rate_tenths_us, offset_tenths_us, good_frames, bad_frames
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   hts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .status     (status),
      .cmd        (cmd)
   );

   hts_dp #(.TALLY_BITS(TALLY_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/hts_div.sv -----
module hts_div
   import hts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DSR_W-1:0]  divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient,
   output logic [DSR_W-1:0]  remainder
);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DIVD_W-1:0] quo_ff;
   logic [DSR_W-1:0]  rem_ff;
   logic [DSR_W-1:0]  dsr_ff;
   logic [DSR_W:0]    trial;
   logic              fits;
   logic [DSR_W-1:0]  rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIVD_W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = fits ? DSR_W'(trial - {1'b0, dsr_ff}) : DSR_W'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[DIVD_W-2:0], fits};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/hts_dp.sv -----
module hts_dp
   import hts_pkg::*;
#(
   parameter int TALLY_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [1:0]    req_tuser,
   input  logic [63:0]   req_tdata,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [16:0]   csr_wdata,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast,
   output logic [87:0]   rsp_tdata
);

   logic [1:0]            cmd_ff;
   logic [31:0]           tus_ff, tms_ff;
   logic [16:0]           iv_ff;
   logic [15:0]           latch_ff, tmo_ff;
   logic [31:0]           last_us_ff, last_ms_ff;
   logic                  link_ff;
   logic [TALLY_BITS-1:0] good_ff, bad_ff;
   logic [31:0]           stats_stamp_ff, sync_stamp_ff;
   logic signed [31:0]    avg_ff;
   logic [15:0]           fill_ff, limit_ff;
   logic signed [47:0]    prod_ff, tdel_ff;
   logic                  neg_ff;
   logic [3:0]            pend_ff;
   logic                  ovalid_ff, olast_ff;
   logic [1:0]            okind_ff;
   logic [83:0]           odata_ff;

   logic [31:0]           du;
   logic                  ge;
   logic [15:0]           fill_inc, fill_new;
   logic signed [47:0]    dlt48, sum;
   logic [47:0]           mag;
   logic                  div_start, div_done;
   logic [DIVD_W-1:0]     dvd, quo;
   logic [DSR_W-1:0]      dsr, rem;
   logic signed [31:0]    avg_res;
   logic [16:0]           iv_wr;
   logic [3:0]            sel;
   logic                  f_sync, f_stats, f_disc;
   logic signed [32:0]    off_wide;
   logic [31:0]           off_sat;
   logic [19:0]           rate_v;
   logic [15:0]           good16, bad16;
   logic [TALLY_BITS-1:0] good_inc, bad_inc;
   logic                  slot_free;

   always_comb begin
      du       = tus_ff - last_us_ff;
      ge       = $signed(du) >= $signed({15'd0, iv_ff});
      fill_inc = fill_ff + 16'd1;
      fill_new = (fill_inc > limit_ff) ? limit_ff : fill_inc;
      dlt48    = 48'(signed'(du));
      sum      = prod_ff + tdel_ff;
      mag      = sum[47] ? 48'(-sum) : 48'(sum);

      div_start = cmd.lim_start || cmd.sum || (cmd.exec && cmd_ff == CMD_RF && ge);
      if (cmd.lim_start) begin
         dvd = WINDOW_SPAN;
         dsr = iv_ff;
      end else if (cmd.sum) begin
         dvd = mag;
         dsr = {1'b0, fill_ff};
      end else begin
         dvd = {16'd0, du};
         dsr = iv_ff;
      end

      if (!neg_ff) begin
         avg_res = (quo > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(32'(quo));
      end else begin
         avg_res = (quo > 48'h8000_0000) ? 32'sh8000_0000 : -signed'(32'(quo));
      end

      if (csr_wdata == 17'd0) iv_wr = 17'd1;
      else if (csr_wdata > INTERVAL_MAX) iv_wr = INTERVAL_MAX;
      else iv_wr = csr_wdata;

      f_sync  = link_ff && ((tms_ff - sync_stamp_ff) >= SYNC_PERIOD_MS);
      f_stats = (tms_ff - stats_stamp_ff) >= {16'd0, latch_ff};
      f_disc  = link_ff && ((tms_ff - last_ms_ff) > {16'd0, tmo_ff});

      if (pend_ff[0]) sel = 4'b0001;
      else if (pend_ff[1]) sel = 4'b0010;
      else if (pend_ff[2]) sel = 4'b0100;
      else if (pend_ff[3]) sel = 4'b1000;
      else sel = 4'b0000;

      off_wide = 33'(signed'(avg_ff)) - signed'(SAFE_MARGIN);
      if (off_wide > 33'sh0_7FFF_FFFF) off_sat = 32'h7FFF_FFFF;
      else if (off_wide < -33'sh0_8000_0000) off_sat = 32'h8000_0000;
      else off_sat = 32'(off_wide);
      rate_v = 20'({3'd0, iv_ff} * 20'd10);

      if (TALLY_BITS > 16 && good_ff > TALLY_BITS'(17'h0FFFF)) good16 = 16'hFFFF;
      else good16 = 16'(good_ff);
      if (TALLY_BITS > 16 && bad_ff > TALLY_BITS'(17'h0FFFF)) bad16 = 16'hFFFF;
      else bad16 = 16'(bad_ff);
      good_inc = (good_ff == '1) ? good_ff : good_ff + 1'b1;
      bad_inc  = (bad_ff == '1) ? bad_ff : bad_ff + 1'b1;

      slot_free = !ovalid_ff || rsp_tready;
   end

   hts_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dvd),
      .divisor   (dsr),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff         <= CMD_GOOD;
         iv_ff          <= INTERVAL_RESET;
         latch_ff       <= LATCH_RESET;
         tmo_ff         <= TIMEOUT_RESET;
         last_us_ff     <= '0;
         last_ms_ff     <= '0;
         link_ff        <= 1'b0;
         good_ff        <= '0;
         bad_ff         <= '0;
         stats_stamp_ff <= '0;
         sync_stamp_ff  <= '0;
         avg_ff         <= '0;
         fill_ff        <= '0;
         limit_ff       <= LIMIT_RESET;
         neg_ff         <= 1'b0;
         pend_ff        <= '0;
         ovalid_ff      <= 1'b0;
      end else begin
         if (cmd.capture) begin
            cmd_ff <= req_tuser;
            tus_ff <= req_tdata[31:0];
            tms_ff <= req_tdata[63:32];
         end
         if (csr_we) begin
            case (csr_index)
               REG_INTERVAL: begin
                  iv_ff         <= iv_wr;
                  avg_ff        <= '0;
                  fill_ff       <= '0;
                  sync_stamp_ff <= sync_stamp_ff - SYNC_PERIOD_MS;
               end
               REG_LATCH:   latch_ff <= csr_wdata[15:0];
               REG_TIMEOUT: tmo_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.exec) begin
            case (cmd_ff)
               CMD_GOOD: begin
                  good_ff    <= good_inc;
                  last_us_ff <= tus_ff;
                  last_ms_ff <= tms_ff;
                  link_ff    <= 1'b1;
                  pend_ff    <= {3'b000, !link_ff};
               end
               CMD_BAD:  bad_ff <= bad_inc;
               CMD_RF:   if (!ge) fill_ff <= fill_new;
               default:  pend_ff <= {f_disc, f_stats, f_sync, 1'b0};
            endcase
         end
         if (cmd.mul) begin
            prod_ff <= 48'(avg_ff * signed'({1'b0, fill_ff - 16'd1}));
            tdel_ff <= (dlt48 <<< 3) + (dlt48 <<< 1);
         end
         if (cmd.sum) neg_ff <= sum[47];
         if (cmd.fin_mod) begin
            avg_ff        <= -signed'(32'({15'd0, rem} * 32'd10));
            fill_ff       <= '0;
            sync_stamp_ff <= sync_stamp_ff - SYNC_PERIOD_MS;
         end
         if (cmd.fin_avg) avg_ff <= avg_res;
         if (cmd.fin_lim) limit_ff <= (quo == '0) ? 16'd1 : quo[15:0];
         if (cmd.emit) begin
            pend_ff   <= pend_ff & ~sel;
            ovalid_ff <= 1'b1;
            olast_ff  <= (pend_ff & ~sel) == 4'b0000;
            odata_ff  <= '0;
            case (sel)
               4'b0010: begin
                  okind_ff       <= KIND_SYNC;
                  odata_ff[19:0] <= rate_v;
                  odata_ff[51:20] <= off_sat;
                  sync_stamp_ff  <= tms_ff;
               end
               4'b0100: begin
                  okind_ff        <= KIND_STATS;
                  odata_ff[67:52] <= good16;
                  odata_ff[83:68] <= bad16;
                  good_ff         <= '0;
                  bad_ff          <= '0;
                  stats_stamp_ff  <= tms_ff;
               end
               4'b1000: begin
                  okind_ff <= KIND_DISC;
                  link_ff  <= 1'b0;
               end
               default: okind_ff <= KIND_CONN;
            endcase
         end else if (rsp_tready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.cmd       = cmd_ff;
      status.rf_ge     = ge;
      status.pend_any  = pend_ff != 4'b0000;
      status.slot_free = slot_free;
      status.div_done  = div_done;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {4'd0, odata_ff};

endmodule

// ----- rtl/hts_ctrl.sv -----
module hts_ctrl
   import hts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_DIVW = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;
   localparam logic [2:0] S_LIM  = 3'd6;

   localparam logic [1:0] DK_MOD = 2'd0;
   localparam logic [1:0] DK_AVG = 2'd1;
   localparam logic [1:0] DK_LIM = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [1:0] dk_ff, dk_in;
   logic       iv_write;

   always_comb begin
      iv_write   = csr_we && csr_index == REG_INTERVAL;
      req_tready = state_ff == S_IDLE && !iv_write;
      cmd        = '0;
      state_in   = state_ff;
      dk_in      = dk_ff;
      case (state_ff)
         S_IDLE: begin
            if (iv_write) begin
               state_in = S_LIM;
            end else if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            case (status.cmd)
               CMD_BAD: state_in = S_IDLE;
               CMD_RF: begin
                  if (status.rf_ge) begin
                     dk_in    = DK_MOD;
                     state_in = S_DIVW;
                  end else begin
                     state_in = S_MUL;
                  end
               end
               default: state_in = S_EMIT;
            endcase
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            dk_in    = DK_AVG;
            state_in = S_DIVW;
         end
         S_LIM: begin
            cmd.lim_start = 1'b1;
            dk_in         = DK_LIM;
            state_in      = S_DIVW;
         end
         S_DIVW: begin
            if (status.div_done) begin
               case (dk_ff)
                  DK_MOD:  cmd.fin_mod = 1'b1;
                  DK_AVG:  cmd.fin_avg = 1'b1;
                  default: cmd.fin_lim = 1'b1;
               endcase
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (!status.pend_any) state_in = S_IDLE;
            else if (status.slot_free) cmd.emit = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dk_ff    <= DK_MOD;
      end else begin
         state_ff <= state_in;
         dk_ff    <= dk_in;
      end
   end

endmodule

// ----- rtl/hts_checker.sv -----
`include "handset_timing_sync_tracker_core_macros.svh"

module hts_checker
   import hts_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast,
   input logic [87:0] rsp_tdata
);

   `HTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `HTS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `HTS_ASSERT_SAME(a_link_clean, clock, reset, rsp_tvalid && (rsp_tuser == KIND_CONN || rsp_tuser == KIND_DISC), rsp_tdata == 88'd0)
   `HTS_ASSERT_SAME(a_conn_last, clock, reset, rsp_tvalid && rsp_tuser == KIND_CONN, rsp_tlast)

endmodule

bind handset_timing_sync_tracker_core hts_checker u_hts_checker (.*);

// ----- sim/hts_event_checker.sv -----
`timescale 1ns / 100ps

module hts_event_checker
   import hts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic [87:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [19:0] rate;
      logic [31:0] offset;
      logic [15:0] good;
      logic [15:0] bad;
      logic        last;
   } report_type;

   report_type due_reports[$];

   logic [16:0] interval_reg;
   logic [15:0] latch_reg;
   logic [15:0] timeout_reg;
   logic [31:0] good_us, good_ms, stats_stamp, sync_stamp;
   logic        link_up;
   logic [15:0] good_tally, bad_tally, fill, fill_limit;
   int          avg_offset;

   function automatic logic [31:0] eff_interval();
      if (interval_reg == 0) return 1;
      if (interval_reg > INTERVAL_MAX) return INTERVAL_MAX;
      return interval_reg;
   endfunction

   function automatic logic [15:0] window_cap();
      logic [31:0] w;
      w = 20000 / eff_interval();
      return (w < 1) ? 16'd1 : w[15:0];
   endfunction

   function automatic int clip32(longint v);
      if (v > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
      if (v < -longint'(64'd2147483648)) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic report_type make_report(logic [1:0] kind, logic [19:0] rate,
                                              logic [31:0] off, logic [15:0] g,
                                              logic [15:0] b);
      report_type r;
      r.kind = kind; r.rate = rate; r.offset = off; r.good = g; r.bad = b; r.last = 0;
      return r;
   endfunction

   task automatic apply_event(logic [1:0] cmd, logic [31:0] tus, logic [31:0] tms);
      report_type  batch[$];
      logic [31:0] iv, du;
      longint      delta;
      logic [15:0] f;
      iv = eff_interval();
      case (cmd)
         CMD_GOOD: begin
            if (good_tally != 16'hFFFF) good_tally++;
            good_us = tus;
            good_ms = tms;
            if (!link_up) begin
               link_up = 1;
               batch.push_back(make_report(KIND_CONN, 0, 0, 0, 0));
            end
         end
         CMD_BAD: begin
            if (bad_tally != 16'hFFFF) bad_tally++;
         end
         CMD_RF: begin
            du = tus - good_us;
            delta = longint'(signed'(du));
            if (delta >= longint'(iv)) begin
               avg_offset = -int'((du % iv) * 10);
               fill = 0;
               sync_stamp = sync_stamp - SYNC_PERIOD_MS;
            end else begin
               f = fill + 1;
               if (f > fill_limit) f = fill_limit;
               fill = f;
               avg_offset = clip32((longint'(avg_offset) * longint'(f - 1) + delta * 10)
                                   / longint'(f));
            end
         end
         default: begin
            if (link_up && (tms - sync_stamp) >= SYNC_PERIOD_MS) begin
               batch.push_back(make_report(KIND_SYNC, 20'(iv * 10),
                                           clip32(longint'(avg_offset) - 1000), 0, 0));
               sync_stamp = tms;
            end
            if ((tms - stats_stamp) >= {16'd0, latch_reg}) begin
               batch.push_back(make_report(KIND_STATS, 0, 0, good_tally, bad_tally));
               good_tally = 0;
               bad_tally = 0;
               stats_stamp = tms;
            end
            if (link_up && (tms - good_ms) > {16'd0, timeout_reg}) begin
               link_up = 0;
               batch.push_back(make_report(KIND_DISC, 0, 0, 0, 0));
            end
         end
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1;
      foreach (batch[i]) due_reports.push_back(batch[i]);
   endtask

   always @(posedge clock) begin
      report_type exp, act;
      if (reset) begin
         interval_reg = INTERVAL_RESET;
         latch_reg = LATCH_RESET;
         timeout_reg = TIMEOUT_RESET;
         good_us = 0; good_ms = 0; link_up = 0;
         good_tally = 0; bad_tally = 0;
         stats_stamp = 0; sync_stamp = 0;
         avg_offset = 0; fill = 0;
         fill_limit = window_cap();
         due_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            act = make_report(rsp_tuser, rsp_tdata[19:0], rsp_tdata[51:20],
                              rsp_tdata[67:52], rsp_tdata[83:68]);
            act.last = rsp_tlast;
            if (due_reports.size() == 0) begin
               $display("%0t: unexpected result kind=%0d data=%h last=%0d",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               exp = due_reports.pop_front();
               if (act.kind != exp.kind || act.rate != exp.rate || act.offset != exp.offset
                   || act.good != exp.good || act.bad != exp.bad || act.last != exp.last
                   || rsp_tdata[87:84] != 0) begin
                  $display("%0t: mismatch expected kind=%0d rate=%0d off=%0d good=%0d bad=%0d last=%0d",
                           $time, exp.kind, exp.rate, $signed(exp.offset), exp.good, exp.bad,
                           exp.last);
                  $display("%0t:          actual kind=%0d rate=%0d off=%0d good=%0d bad=%0d last=%0d",
                           $time, act.kind, act.rate, $signed(act.offset), act.good, act.bad,
                           act.last);
                  errors++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_INTERVAL: begin
                  interval_reg = csr_wdata;
                  avg_offset = 0;
                  fill = 0;
                  fill_limit = window_cap();
                  sync_stamp = sync_stamp - SYNC_PERIOD_MS;
               end
               REG_LATCH:   latch_reg = csr_wdata[15:0];
               REG_TIMEOUT: timeout_reg = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) apply_event(req_tuser, req_tdata[31:0], req_tdata[63:32]);
      end
      pending = due_reports.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end

endmodule

// ----- sim/handset_timing_sync_tracker_core_test.sv -----
`timescale 1ns / 100ps

module handset_timing_sync_tracker_core_test;
   import hts_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 84;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [1:0]  req_tuser = 0;
   logic [63:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic [87:0] rsp_tdata;
   logic        csr_we = 0;
   logic [1:0]  csr_index = 0;
   logic [16:0] csr_wdata = 0;
   int          errors, pending, cycles;

   logic [31:0] now_us, now_ms, frac_us, last_good_us;
   logic [31:0] span;
   int          stall_mode, stall_count;

   handset_timing_sync_tracker_core DUT (.*);

   hts_event_checker checker_inst (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_count = $urandom_range(16, 96);
      end
      stall_count--;
      case (stall_mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_count % 5 != 0);
      endcase
   end

   task automatic send(logic [1:0] cmd, logic [31:0] tus, logic [31:0] tms);
      @(negedge clock);
      req_tvalid = 1;
      req_tuser = cmd;
      req_tdata = {tms, tus};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_GOOD) last_good_us = tus;
   endtask

   task automatic pause(int n);
      @(negedge clock);
      req_tvalid = 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic settle();
      pause(0);
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [16:0] val);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic advance(logic [31:0] d);
      now_us += d;
      frac_us += d;
      now_ms += frac_us / 1000;
      frac_us = frac_us % 1000;
   endtask

   task automatic random_event();
      int r, c;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         send(2'($urandom_range(0, 3)), $urandom, $urandom);
      end else begin
         if (r < 14) begin
            now_ms += $urandom_range(0, 3000);
         end else begin
            advance($urandom_range(0, span));
         end
         c = $urandom_range(0, 99);
         if (c < 25) send(CMD_GOOD, now_us, now_ms);
         else if (c < 35) send(CMD_BAD, now_us, now_ms);
         else if (c < 68) send(CMD_RF, last_good_us + $urandom_range(0, span + span / 4), now_ms);
         else send(CMD_POLL, now_us, now_ms);
      end
   endtask

   initial begin
      logic [16:0] iv_set[5] = '{17'd0, 17'd131071, 17'd1, 17'd100000, 17'd4000};
      logic [15:0] latch_set[5] = '{16'd1, 16'd65535, 16'd500, 16'd2000, 16'd200};
      logic [15:0] tmo_set[5] = '{16'd1, 16'd65535, 16'd300, 16'd5000, 16'd1000};
      int n;
      cycles = 0;
      stall_count = 0;
      frac_us = 0;
      last_good_us = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed
      send(CMD_POLL, 0, 0);
      send(CMD_BAD, 0, 0);
      send(CMD_GOOD, 0, 0);
      send(CMD_RF, 100, 0);
      send(CMD_RF, 3999, 1);
      send(CMD_RF, 4000, 1);
      send(CMD_RF, 32'hFFFF_FF00, 2);
      send(CMD_RF, 32'h8000_0000, 2);
      send(CMD_RF, 32'h7FFF_FFFF, 2);
      send(CMD_POLL, 300, 300);
      send(CMD_POLL, 400, 400);
      send(CMD_GOOD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(CMD_RF, 32'd10, 32'hFFFF_FFFF);
      send(CMD_BAD, 1, 1);
      send(CMD_POLL, 5000, 5000);
      send(CMD_POLL, 5001, 5001);
      send(CMD_GOOD, 6000, 6000);
      send(CMD_RF, 6500, 6000);
      send(CMD_POLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(CMD_POLL, 0, 32'h7FFF_FFFF);
      settle();

      now_us = $urandom;
      now_ms = $urandom;
      for (int p = 0; p < 5; p++) begin
         csr_write(REG_INTERVAL, iv_set[p]);
         csr_write(REG_LATCH, latch_set[p]);
         csr_write(REG_TIMEOUT, tmo_set[p]);
         if (p == 2) csr_write(2'd3, 17'h1FFFF);
         span = (iv_set[p] == 0) ? 1 : (iv_set[p] > INTERVAL_MAX) ? INTERVAL_MAX : iv_set[p];
         span = span * 2;
         send(CMD_GOOD, now_us, now_ms);
         n = 1;
         while (n < PHASE_ITEMS) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < PHASE_ITEMS; b++) begin
               random_event();
               n++;
               if (p == 1 && n == 40) begin
                  pause(0);
                  while (pending != 0) @(negedge clock);
               end
            end
            if ($urandom_range(0, 3) != 0) pause($urandom_range(0, 30));
         end
         settle();
      end

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
